### rtl/cfc_pkg.sv
package cfc_pkg;

   // Default geometry, handed to the top-level parameters.
   localparam int CHUNK_WIDTH_DEF  = 16;
   localparam int CHUNK_HEIGHT_DEF = 256;
   localparam int MAX_CHUNKS_DEF   = 4096;

   localparam int PLANE_COUNT = 6;
   localparam int QUEUE_DEPTH = 4;

   // Fixed field widths.
   localparam int COORD_W       = 12;
   localparam int BLOCK_W       = 17;
   localparam int CHUNK_TOTAL_W = 13;
   localparam int BLOCK_TOTAL_W = 29;
   localparam int NORM_W        = 12;
   localparam int DIST_W        = 28;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [BLOCK_TOTAL_W-1:0] BLOCK_LIMIT     = BLOCK_TOTAL_W'(268435456);
   localparam logic [CHUNK_TOTAL_W-1:0] CHUNK_FIELD_MAX = '1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_LEFT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CULL_ENABLE = 3'd6;

   // One plane as it is packed in its 64-bit register.
   typedef struct packed {
      logic signed [DIST_W-1:0] offset;
      logic signed [NORM_W-1:0] nz;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nx;
   } plane_type;

   // A classified request waiting for the frame counters.
   typedef struct packed {
      logic               visible;
      logic [BLOCK_W-1:0] block_count;
      logic               frame_start;
   } cull_item_type;

endpackage

### rtl/cfc_front.sv
module cfc_front #(
   parameter int CHUNK_WIDTH  = cfc_pkg::CHUNK_WIDTH_DEF,
   parameter int CHUNK_HEIGHT = cfc_pkg::CHUNK_HEIGHT_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_push,
   output logic                                         req_full,
   input  logic signed [cfc_pkg::COORD_W-1:0]           req_chunk_x,
   input  logic signed [cfc_pkg::COORD_W-1:0]           req_chunk_z,
   input  logic [cfc_pkg::BLOCK_W-1:0]                  req_block_count,
   input  logic                                         req_frame_start,
   input  cfc_pkg::plane_type [cfc_pkg::PLANE_COUNT-1:0] planes,
   input  logic                                         cull_enable,
   input  logic                                         q_full,
   output logic                                         q_push,
   output cfc_pkg::cull_item_type                       q_item
);
   import cfc_pkg::*;

   localparam int CW_BITS = $clog2(CHUNK_WIDTH + 1);
   localparam int XW      = COORD_W + CW_BITS + 1;
   localparam int YW      = $clog2(CHUNK_HEIGHT + 1) + 1;
   localparam int PXW     = NORM_W + XW;
   localparam int PYW     = NORM_W + YW;
   localparam int PMAX    = (PXW > PYW) ? PXW : PYW;
   localparam int SUM_W   = ((PMAX > DIST_W) ? PMAX : DIST_W) + 2;

   localparam logic signed [XW-1:0] CW_S = XW'(CHUNK_WIDTH);
   localparam logic signed [YW-1:0] CH_S = YW'(CHUNK_HEIGHT);

   logic stall;
   logic advance;

   // Stage 1: box origin.
   logic                    s1_valid_ff;
   logic signed [XW-1:0]    s1_x0_ff, s1_z0_ff;
   logic [BLOCK_W-1:0]      s1_blocks_ff;
   logic                    s1_start_ff;
   logic signed [XW-1:0]    s1_x0_in, s1_z0_in;

   // Stage 2: per-plane products of the normal and the chosen corner.
   logic                    s2_valid_ff;
   logic [BLOCK_W-1:0]      s2_blocks_ff;
   logic                    s2_start_ff;
   logic signed [PXW-1:0]   s2_px_ff [PLANE_COUNT];
   logic signed [PYW-1:0]   s2_py_ff [PLANE_COUNT];
   logic signed [PXW-1:0]   s2_pz_ff [PLANE_COUNT];
   logic signed [PXW-1:0]   s2_px_in [PLANE_COUNT];
   logic signed [PYW-1:0]   s2_py_in [PLANE_COUNT];
   logic signed [PXW-1:0]   s2_pz_in [PLANE_COUNT];
   logic signed [XW-1:0]    x1, z1;

   // Stage 3: partial sums of the signed distance.
   logic                    s3_valid_ff;
   logic [BLOCK_W-1:0]      s3_blocks_ff;
   logic                    s3_start_ff;
   logic signed [SUM_W-1:0] s3_sa_ff [PLANE_COUNT];
   logic signed [SUM_W-1:0] s3_sb_ff [PLANE_COUNT];
   logic signed [SUM_W-1:0] s3_sa_in [PLANE_COUNT];
   logic signed [SUM_W-1:0] s3_sb_in [PLANE_COUNT];
   logic signed [SUM_W-1:0] dist_sum [PLANE_COUNT];
   logic [PLANE_COUNT-1:0]  plane_ok;

   // The whole pipeline holds while its last stage cannot enter the queue.
   assign stall    = s3_valid_ff & q_full;
   assign advance  = ~stall;
   assign req_full = stall;

   assign s1_x0_in = XW'(req_chunk_x) * CW_S;
   assign s1_z0_in = XW'(req_chunk_z) * CW_S;
   assign x1       = s1_x0_ff + CW_S;
   assign z1       = s1_z0_ff + CW_S;

   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         // A non-negative normal component takes the far edge of the box.
         s2_px_in[p] = PXW'(planes[p].nx) * PXW'(planes[p].nx[NORM_W-1] ? s1_x0_ff : x1);
         s2_py_in[p] = PYW'(planes[p].ny) * PYW'(planes[p].ny[NORM_W-1] ? '0 : CH_S);
         s2_pz_in[p] = PXW'(planes[p].nz) * PXW'(planes[p].nz[NORM_W-1] ? s1_z0_ff : z1);
         s3_sa_in[p] = SUM_W'(s2_px_ff[p]) + SUM_W'(s2_py_ff[p]);
         s3_sb_in[p] = SUM_W'(s2_pz_ff[p]) + SUM_W'(planes[p].offset);
         dist_sum[p] = s3_sa_ff[p] + s3_sb_ff[p];
         plane_ok[p] = ~dist_sum[p][SUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_push;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x0_ff     <= s1_x0_in;
         s1_z0_ff     <= s1_z0_in;
         s1_blocks_ff <= req_block_count;
         s1_start_ff  <= req_frame_start;
         s2_blocks_ff <= s1_blocks_ff;
         s2_start_ff  <= s1_start_ff;
         s3_blocks_ff <= s2_blocks_ff;
         s3_start_ff  <= s2_start_ff;
         for (int p = 0; p < PLANE_COUNT; p++) begin
            s2_px_ff[p] <= s2_px_in[p];
            s2_py_ff[p] <= s2_py_in[p];
            s2_pz_ff[p] <= s2_pz_in[p];
            s3_sa_ff[p] <= s3_sa_in[p];
            s3_sb_ff[p] <= s3_sb_in[p];
         end
      end
   end

   assign q_push             = s3_valid_ff & ~q_full;
   assign q_item.visible     = ~cull_enable | (&plane_ok);
   assign q_item.block_count = s3_blocks_ff;
   assign q_item.frame_start = s3_start_ff;

endmodule

### rtl/cfc_queue.sv
module cfc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cfc_pkg::cull_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output cfc_pkg::cull_item_type head_item
);
   import cfc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cull_item_type       entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/cfc_back.sv
module cfc_back #(
   parameter int MAX_CHUNKS = cfc_pkg::MAX_CHUNKS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   input  cfc_pkg::cull_item_type               q_item,
   output logic                                 q_pop,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_visible,
   output logic [cfc_pkg::CHUNK_TOTAL_W-1:0]    rsp_chunks_drawn,
   output logic [cfc_pkg::BLOCK_TOTAL_W-1:0]    rsp_blocks_drawn
);
   import cfc_pkg::*;

   localparam logic [CHUNK_TOTAL_W-1:0] CHUNK_CAP =
      (MAX_CHUNKS > 8191) ? CHUNK_FIELD_MAX : CHUNK_TOTAL_W'(MAX_CHUNKS);

   logic                       out_valid_ff;
   logic                       take;
   logic [CHUNK_TOTAL_W-1:0]   chunk_total_ff, chunk_total_in, chunk_base;
   logic [BLOCK_TOTAL_W-1:0]   block_total_ff, block_total_in, block_base;
   logic [BLOCK_TOTAL_W:0]     block_sum;
   logic                       visible_ff;

   // The output register frees up in the same cycle that it is popped.
   assign take  = ~q_empty & (~out_valid_ff | rsp_pop);
   assign q_pop = take;

   always_comb begin
      chunk_base     = q_item.frame_start ? '0 : chunk_total_ff;
      block_base     = q_item.frame_start ? '0 : block_total_ff;
      block_sum      = {1'b0, block_base} + (BLOCK_TOTAL_W + 1)'(q_item.block_count);
      chunk_total_in = chunk_base;
      block_total_in = block_base;
      if (q_item.visible) begin
         chunk_total_in = (chunk_base < CHUNK_CAP) ? chunk_base + 1'b1 : CHUNK_CAP;
         block_total_in = (block_sum > {1'b0, BLOCK_LIMIT}) ? BLOCK_LIMIT
                                                             : block_sum[BLOCK_TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         chunk_total_ff <= '0;
         block_total_ff <= '0;
      end else begin
         if (take) begin
            out_valid_ff   <= 1'b1;
            chunk_total_ff <= chunk_total_in;
            block_total_ff <= block_total_in;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         visible_ff <= q_item.visible;
      end
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_visible      = visible_ff;
   assign rsp_chunks_drawn = chunk_total_ff;
   assign rsp_blocks_drawn = block_total_ff;

endmodule

### rtl/chunk_frustum_cull_top.sv
// Chunk frustum culler.
// Requests enter through a queue-like port: a chunk's grid column and row, its block
// count and a frame-start mark are taken at a clock edge with req_push high and
// req_full low. Results leave the same way: while rsp_empty is low the oldest result
// (visible flag and the running per-frame chunk and block totals) is on the rsp_ ports,
// and rsp_pop takes it. The csr_ port writes the six packed frustum planes (indexes 0
// to 5) and the culling enable (index 6); other indexes are dropped. A request passes
// three stages of plane arithmetic (corner, products, partial sums), the final sign
// test into a four-entry queue, and the frame counters into the output register. One
// request is taken every cycle while req_full is low; the frame counters are the only
// state carried between requests. When rsp_pop is held low the output register and
// queue fill, then the plane pipeline holds and req_full rises. Synchronous reset
// empties the pipeline and queue and clears the counters and every configuration
// register, so culling starts disabled.
module chunk_frustum_cull_top #(
   parameter int CHUNK_WIDTH  = cfc_pkg::CHUNK_WIDTH_DEF,
   parameter int CHUNK_HEIGHT = cfc_pkg::CHUNK_HEIGHT_DEF,
   parameter int MAX_CHUNKS   = cfc_pkg::MAX_CHUNKS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [cfc_pkg::COORD_W-1:0]   req_chunk_x,
   input  logic signed [cfc_pkg::COORD_W-1:0]   req_chunk_z,
   input  logic [cfc_pkg::BLOCK_W-1:0]          req_block_count,
   input  logic                                 req_frame_start,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_visible,
   output logic [cfc_pkg::CHUNK_TOTAL_W-1:0]    rsp_chunks_drawn,
   output logic [cfc_pkg::BLOCK_TOTAL_W-1:0]    rsp_blocks_drawn,
   input  logic                                 csr_write,
   input  logic [cfc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cfc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cfc_pkg::*;

   plane_type [PLANE_COUNT-1:0] planes_ff;
   logic                        cull_enable_ff;

   logic                        q_push, q_full, q_pop, q_empty;
   cull_item_type               q_in_item, q_head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff      <= '0;
         cull_enable_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_index < CSR_CULL_ENABLE) begin
            planes_ff[csr_index - CSR_PLANE_LEFT] <= plane_type'(csr_wdata);
         end else if (csr_index == CSR_CULL_ENABLE) begin
            cull_enable_ff <= csr_wdata[0];
         end
      end
   end

   cfc_front #(
      .CHUNK_WIDTH  (CHUNK_WIDTH),
      .CHUNK_HEIGHT (CHUNK_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_chunk_x     (req_chunk_x),
      .req_chunk_z     (req_chunk_z),
      .req_block_count (req_block_count),
      .req_frame_start (req_frame_start),
      .planes          (planes_ff),
      .cull_enable     (cull_enable_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_in_item)
   );

   cfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head_item)
   );

   cfc_back #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_item           (q_head_item),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_visible      (rsp_visible),
      .rsp_chunks_drawn (rsp_chunks_drawn),
      .rsp_blocks_drawn (rsp_blocks_drawn)
   );

endmodule
